// ===== rtl/core/led_profile_crossfade_engine_assert.svh =====
// assertion macros for the led profile crossfade engine
`ifndef LED_PROFILE_CROSSFADE_ENGINE_ASSERT_SVH
`define LED_PROFILE_CROSSFADE_ENGINE_ASSERT_SVH

// same-cycle implication
`define LPCE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lpce assertion failed");

// next-cycle implication
`define LPCE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lpce assertion failed");

`endif

// ===== rtl/core/lpce_pkg.sv =====
// shared types, constants and profile functions of the led profile crossfade engine
`timescale 1ns / 1ps

package lpce_pkg;

  localparam int unsigned NUM_PROFILES = 6;
  localparam int unsigned TABLE_SIZE   = 6;

  // progress fraction and eased weight
  localparam int unsigned Q_BITS = 10;
  localparam int unsigned Q_ONE  = 1 << Q_BITS;
  localparam int unsigned E_W    = Q_BITS + 1;

  // divider and multiplier widths
  localparam int unsigned DEN_W = 16;
  localparam int unsigned MUL_W = 12;
  localparam int unsigned PRD_W = 2 * MUL_W;

  // light sleep: ceil(30 * x / 100) == (3 * x + 9) / 10, /10 by reciprocal
  localparam int unsigned DIM_MUL   = 3;
  localparam int unsigned DIM_ADD   = 9;
  localparam int unsigned DIM_RECIP = 205;
  localparam int unsigned DIM_SHIFT = 11;

  localparam logic [23:0] EMOTION_RESET = 24'hFFF1D6;

  typedef enum logic [1:0] {
    MODE_TICK,
    MODE_SET,
    MODE_FADE,
    MODE_SLEEP
  } mode_e;

  typedef enum logic [1:0] {
    CMD_OFF,
    CMD_SOLID,
    CMD_BREATH
  } cmd_e;

  typedef struct packed {
    logic [6:0]  lo;
    logic [6:0]  hi;
    logic [15:0] period;
    logic [23:0] color;
    logic        solid;
  } profile_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [6:0]  lo;
    logic [6:0]  hi;
    logic [15:0] period;
    logic [23:0] color;
  } beat_t;

  localparam profile_t COLD_PROFILE = '{
    lo: 7'd10, hi: 7'd15, period: 16'd6000, color: 24'h4477AA, solid: 1'b0
  };

  function automatic logic idx_ok(logic [2:0] idx);
    return (32'(idx) < NUM_PROFILES) && (32'(idx) < TABLE_SIZE);
  endfunction

  function automatic profile_t pick_profile(logic [2:0] idx, logic [23:0] emo);
    profile_t p;
    p = '0;
    unique case (idx)
      3'd0: p = '{lo: 7'd0,  hi: 7'd0,  period: 16'd0,    color: 24'h000000, solid: 1'b1};
      3'd1: p = '{lo: 7'd5,  hi: 7'd15, period: 16'd4000, color: 24'hFFF1D6, solid: 1'b0};
      3'd2: p = '{lo: 7'd18, hi: 7'd22, period: 16'd4000, color: 24'hFFD27A, solid: 1'b0};
      3'd3: p = '{lo: 7'd35, hi: 7'd50, period: 16'd700,  color: 24'hFF8A35, solid: 1'b0};
      3'd4: p = '{lo: 7'd70, hi: 7'd70, period: 16'd0,    color: emo,        solid: 1'b1};
      3'd5: p = '{lo: 7'd5,  hi: 7'd10, period: 16'd6000, color: 24'h69849E, solid: 1'b0};
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic logic [6:0] dim_level(logic [6:0] lvl);
    logic [8:0]  y;
    logic [16:0] prod;
    y    = 9'(DIM_MUL) * {2'b00, lvl} + 9'(DIM_ADD);
    prod = {8'd0, y} * 17'(DIM_RECIP);
    return 7'(prod >> DIM_SHIFT);
  endfunction

  function automatic beat_t shape(profile_t p, logic dim, logic deep);
    profile_t s;
    beat_t    b;
    s = p;
    if (dim) begin
      if (deep) begin
        s = COLD_PROFILE;
      end else begin
        s.lo = dim_level(p.lo);
        s.hi = dim_level(p.hi);
      end
    end
    b = '0;
    if (s.hi != '0) begin
      if (s.solid) begin
        b.cmd   = CMD_SOLID;
        b.hi    = s.hi;
        b.color = s.color;
      end else begin
        b.cmd    = CMD_BREATH;
        b.lo     = s.lo;
        b.hi     = s.hi;
        b.period = s.period;
        b.color  = s.color;
      end
    end
    return b;
  endfunction

endpackage

// ===== rtl/core/lpce_div.sv =====
// serial restoring divider, one quotient bit per cycle, for fade progress
`timescale 1ns / 1ps

module lpce_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lpce_pkg::DEN_W-1:0]   dividend_i,
  input  logic [lpce_pkg::DEN_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [lpce_pkg::Q_BITS-1:0]  quot_o
);

  localparam int unsigned CntW = $clog2(lpce_pkg::Q_BITS);

  logic [lpce_pkg::DEN_W-1:0]  rem_q;
  logic [lpce_pkg::Q_BITS-1:0] quot_q;
  logic [CntW-1:0]             cnt_q;
  logic                        run_q;
  logic                        done_q;
  logic [lpce_pkg::DEN_W:0]    shifted;
  logic [lpce_pkg::DEN_W:0]    trial;
  logic                        fits;

  assign shifted = {rem_q, 1'b0};
  assign trial   = shifted - {1'b0, divisor_i};
  assign fits    = shifted >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quot_q <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= dividend_i;
        quot_q <= '0;
        cnt_q  <= '0;
        run_q  <= 1'b1;
      end else if (run_q) begin
        rem_q  <= fits ? trial[lpce_pkg::DEN_W-1:0] : shifted[lpce_pkg::DEN_W-1:0];
        quot_q <= {quot_q[lpce_pkg::Q_BITS-2:0], fits};
        cnt_q  <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(lpce_pkg::Q_BITS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/core/lpce_mul.sv =====
// shared signed multiplier with registered product
`timescale 1ns / 1ps

module lpce_mul (
  input  logic                               clk_i,
  input  logic signed [lpce_pkg::MUL_W-1:0]  a_i,
  input  logic signed [lpce_pkg::MUL_W-1:0]  b_i,
  output logic signed [lpce_pkg::PRD_W-1:0]  prod_o
);

  logic signed [lpce_pkg::PRD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/core/led_profile_crossfade_engine.sv =====
// led profile crossfade engine top level: sequencer, profile state and output register
// a fade tick that has not ended passes through the divider, the ease square, five blend
//   passes through the one multiplier and the output register before its beat
// an ending tick skips the divider and gives two beats, the blended frame then the target
// the input stalls until the sequencer is back in idle; fade starts and ticks with no fade
//   do not leave idle, and a stalled output beat holds the sequencer in its emit step
// reset: async active low, all profiles zero, no fade, no sleep, colour 0xFFF1D6
`timescale 1ns / 1ps

module led_profile_crossfade_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] now_ms_i,
  input  logic [2:0]  state_index_i,
  input  logic [15:0] duration_ms_i,
  input  logic        sleeping_i,
  input  logic        deep_sleep_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  drive_command_o,
  output logic [6:0]  low_level_o,
  output logic [6:0]  high_level_o,
  output logic [15:0] breath_period_ms_o,
  output logic [23:0] rgb_color_o,
  output logic        in_transition_o,
  output logic        last_of_run_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_EASE,
    S_BLEND,
    S_ACC,
    S_EMIT_FRAME,
    S_EMIT_TGT,
    S_EMIT_CUR
  } state_e;

  typedef enum logic [2:0] {
    CH_LO,
    CH_HI,
    CH_R,
    CH_G,
    CH_B
  } chan_e;

  localparam int unsigned EW = lpce_pkg::E_W;
  localparam int unsigned MW = lpce_pkg::MUL_W;
  localparam int unsigned PW = lpce_pkg::PRD_W;
  localparam int unsigned QB = lpce_pkg::Q_BITS;

  state_e              state_q;
  chan_e               chan_q;
  chan_e               chan_nxt;
  lpce_pkg::profile_t  current_q;
  lpce_pkg::profile_t  source_q;
  lpce_pkg::profile_t  target_q;
  logic [31:0]         start_q;
  logic [15:0]         len_q;
  logic                fading_q;
  logic                dim_q;
  logic                deep_q;
  logic [23:0]         emo_q;
  logic                done_q;
  logic [EW-1:0]       e_q;
  logic [6:0]          frame_lo_q;
  logic [6:0]          frame_hi_q;
  logic [23:0]         frame_color_q;
  lpce_pkg::beat_t     out_beat_q;
  logic                out_trans_q;
  logic                out_last_q;
  logic                out_valid_q;

  logic                accept;
  logic                slot_free;
  logic                out_load;
  logic [31:0]         elapsed;
  logic                done_c;
  logic                div_start;
  logic                div_done;
  logic [QB-1:0]       div_quot;
  logic [EW-1:0]       d_c;
  logic [7:0]          from8;
  logic [7:0]          to8;
  logic signed [8:0]   diff;
  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] quot_t;
  logic [7:0]          res8;
  lpce_pkg::profile_t  pick;
  lpce_pkg::profile_t  frame_p;

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign out_load  = slot_free && ((state_q == S_EMIT_FRAME) || (state_q == S_EMIT_TGT)
                                   || (state_q == S_EMIT_CUR));
  assign elapsed   = now_ms_i - start_q;
  assign done_c    = elapsed >= {16'd0, len_q};
  assign div_start = accept && (lpce_pkg::mode_e'(mode_i) == lpce_pkg::MODE_TICK)
                     && fading_q && !done_c;
  assign pick      = lpce_pkg::pick_profile(state_index_i, emo_q);
  assign d_c       = EW'(lpce_pkg::Q_ONE) - {1'b0, div_quot};

  assign frame_p = '{lo: frame_lo_q, hi: frame_hi_q, period: target_q.period,
                     color: frame_color_q, solid: 1'b1};

  lpce_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (elapsed[15:0]),
    .divisor_i  (len_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  lpce_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // channel operands
  always_comb begin
    from8    = '0;
    to8      = '0;
    chan_nxt = CH_LO;
    unique case (chan_q)
      CH_LO: begin
        from8    = {1'b0, source_q.lo};
        to8      = {1'b0, target_q.lo};
        chan_nxt = CH_HI;
      end
      CH_HI: begin
        from8    = {1'b0, source_q.hi};
        to8      = {1'b0, target_q.hi};
        chan_nxt = CH_R;
      end
      CH_R: begin
        from8    = source_q.color[23:16];
        to8      = target_q.color[23:16];
        chan_nxt = CH_G;
      end
      CH_G: begin
        from8    = source_q.color[15:8];
        to8      = target_q.color[15:8];
        chan_nxt = CH_B;
      end
      CH_B: begin
        from8    = source_q.color[7:0];
        to8      = target_q.color[7:0];
        chan_nxt = CH_LO;
      end
      default: begin
        from8    = '0;
        to8      = '0;
        chan_nxt = CH_LO;
      end
    endcase
  end

  assign diff = $signed({1'b0, to8}) - $signed({1'b0, from8});

  // multiplier operands: ease square while the divider finishes, else blend
  always_comb begin
    if (state_q == S_DIV) begin
      mul_a = {1'b0, d_c};
      mul_b = {1'b0, d_c};
    end else begin
      mul_a = {{(MW-9){diff[8]}}, diff};
      mul_b = {1'b0, e_q};
    end
  end

  // divide by one q unit, truncated toward zero
  assign quot_t = prod[PW-1] ? ((prod + PW'(lpce_pkg::Q_ONE - 1)) >>> QB) : (prod >>> QB);
  assign res8   = from8 + quot_t[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      chan_q        <= CH_LO;
      current_q     <= '0;
      source_q      <= '0;
      target_q      <= '0;
      start_q       <= '0;
      len_q         <= '0;
      fading_q      <= 1'b0;
      dim_q         <= 1'b0;
      deep_q        <= 1'b0;
      emo_q         <= lpce_pkg::EMOTION_RESET;
      done_q        <= 1'b0;
      e_q           <= '0;
      frame_lo_q    <= '0;
      frame_hi_q    <= '0;
      frame_color_q <= '0;
      out_beat_q    <= '0;
      out_trans_q   <= 1'b0;
      out_last_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        emo_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            unique case (lpce_pkg::mode_e'(mode_i))
              lpce_pkg::MODE_TICK: begin
                if (fading_q) begin
                  done_q <= done_c;
                  if (done_c) begin
                    e_q     <= EW'(lpce_pkg::Q_ONE);
                    chan_q  <= CH_LO;
                    state_q <= S_BLEND;
                  end else begin
                    state_q <= S_DIV;
                  end
                end
              end
              lpce_pkg::MODE_SET: begin
                if (lpce_pkg::idx_ok(state_index_i)) begin
                  current_q <= pick;
                  fading_q  <= 1'b0;
                  state_q   <= S_EMIT_CUR;
                end
              end
              lpce_pkg::MODE_FADE: begin
                if (lpce_pkg::idx_ok(state_index_i)) begin
                  source_q <= current_q;
                  target_q <= pick;
                  start_q  <= now_ms_i;
                  len_q    <= (duration_ms_i == '0) ? 16'd1 : duration_ms_i;
                  fading_q <= 1'b1;
                end
              end
              lpce_pkg::MODE_SLEEP: begin
                dim_q   <= sleeping_i;
                deep_q  <= deep_sleep_i;
                state_q <= S_EMIT_CUR;
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_EASE;
          end
        end
        S_EASE: begin
          e_q     <= EW'(lpce_pkg::Q_ONE) - prod[2*QB:QB];
          chan_q  <= CH_LO;
          state_q <= S_BLEND;
        end
        S_BLEND: begin
          state_q <= S_ACC;
        end
        S_ACC: begin
          unique case (chan_q)
            CH_LO:   frame_lo_q            <= res8[6:0];
            CH_HI:   frame_hi_q            <= res8[6:0];
            CH_R:    frame_color_q[23:16]  <= res8;
            CH_G:    frame_color_q[15:8]   <= res8;
            CH_B:    frame_color_q[7:0]    <= res8;
            default: frame_lo_q            <= frame_lo_q;
          endcase
          chan_q <= chan_nxt;
          if (chan_q == CH_B) begin
            state_q <= S_EMIT_FRAME;
          end else begin
            state_q <= S_BLEND;
          end
        end
        S_EMIT_FRAME: begin
          if (slot_free) begin
            out_beat_q  <= lpce_pkg::shape(frame_p, dim_q, deep_q);
            out_trans_q <= !done_q;
            out_last_q  <= !done_q;
            state_q     <= done_q ? S_EMIT_TGT : S_IDLE;
          end
        end
        S_EMIT_TGT: begin
          if (slot_free) begin
            out_beat_q  <= lpce_pkg::shape(target_q, dim_q, deep_q);
            out_trans_q <= 1'b0;
            out_last_q  <= 1'b1;
            current_q   <= target_q;
            fading_q    <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        S_EMIT_CUR: begin
          if (slot_free) begin
            out_beat_q  <= lpce_pkg::shape(current_q, dim_q, deep_q);
            out_trans_q <= fading_q;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_stall_o         = (state_q != S_IDLE);
  assign out_valid_o        = out_valid_q;
  assign drive_command_o    = out_beat_q.cmd;
  assign low_level_o        = out_beat_q.lo;
  assign high_level_o       = out_beat_q.hi;
  assign breath_period_ms_o = out_beat_q.period;
  assign rgb_color_o        = out_beat_q.color;
  assign in_transition_o    = out_trans_q;
  assign last_of_run_o      = out_last_q;

endmodule

// ===== rtl/core/lpce_checker.sv =====
// port-level assertions for the led profile crossfade engine, with bind
`timescale 1ns / 1ps
`include "led_profile_crossfade_engine_assert.svh"

module lpce_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [23:0] cfg_wdata_i,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  mode_i,
  input logic [31:0] now_ms_i,
  input logic [2:0]  state_index_i,
  input logic [15:0] duration_ms_i,
  input logic        sleeping_i,
  input logic        deep_sleep_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  drive_command_o,
  input logic [6:0]  low_level_o,
  input logic [6:0]  high_level_o,
  input logic [15:0] breath_period_ms_o,
  input logic [23:0] rgb_color_o,
  input logic        in_transition_o,
  input logic        last_of_run_o
);

  // stalled beat holds
  `LPCE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(rgb_color_o) && $stable(high_level_o) && $stable(last_of_run_o))

  // only a finishing fade gives two beats, and it has ended
  `LPCE_ASSERT_IMPL(a_first_ends_fade, clk_i, rst_ni, out_valid_o && !last_of_run_o, !in_transition_o)

  // off beats carry no levels, period or colour
  `LPCE_ASSERT_IMPL(a_off_zero, clk_i, rst_ni, out_valid_o && drive_command_o == lpce_pkg::CMD_OFF, low_level_o == 7'd0 && high_level_o == 7'd0 && breath_period_ms_o == 16'd0 && rgb_color_o == 24'd0)

  // solid beats have a level and no breathing fields
  `LPCE_ASSERT_IMPL(a_solid_fields, clk_i, rst_ni, out_valid_o && drive_command_o == lpce_pkg::CMD_SOLID, low_level_o == 7'd0 && breath_period_ms_o == 16'd0 && high_level_o != 7'd0)

  // a valid set-state item keeps the engine busy for its beat
  `LPCE_ASSERT_NEXT(a_set_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && mode_i == lpce_pkg::MODE_SET && 32'(state_index_i) < lpce_pkg::NUM_PROFILES, in_stall_o)

  logic unused_ok;
  assign unused_ok = ^{cfg_we_i, cfg_wdata_i, now_ms_i, duration_ms_i, sleeping_i,
                       deep_sleep_i};

endmodule

bind led_profile_crossfade_engine lpce_checker u_lpce_checker (.*);

// ===== bench/led_profile_crossfade_engine_checker.sv =====
// checker for the led profile crossfade engine: predicts every output beat and compares it
`timescale 1ns / 1ps

module led_profile_crossfade_engine_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  mode_i,
  input  logic [31:0] now_ms_i,
  input  logic [2:0]  state_index_i,
  input  logic [15:0] duration_ms_i,
  input  logic        sleeping_i,
  input  logic        deep_sleep_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  drive_command_i,
  input  logic [6:0]  low_level_i,
  input  logic [6:0]  high_level_i,
  input  logic [15:0] breath_period_ms_i,
  input  logic [23:0] rgb_color_i,
  input  logic        in_transition_i,
  input  logic        last_of_run_i,
  output int unsigned frames_pending_o,
  output int unsigned mismatches_o
);
  import lpce_pkg::*;

  localparam int UNIT = 1024;

  typedef struct packed {
    cmd_e        cmd;
    logic [6:0]  lo;
    logic [6:0]  hi;
    logic [15:0] period;
    logic [23:0] color;
    logic        fading;
    logic        last;
  } frame_t;

  localparam profile_t COLD = '{7'd10, 7'd15, 16'd6000, 24'h4477AA, 1'b0};

  logic [23:0] mood_rgb;
  profile_t    live_p;
  profile_t    from_p;
  profile_t    to_p;
  logic [31:0] fade_t0;
  logic [15:0] fade_span;
  logic        fade_on;
  logic        dim_on;
  logic        deep_on;
  frame_t      frames_due[$];
  int unsigned fails   = 0;
  int unsigned beat_no = 0;

  assign mismatches_o = fails;

  function automatic profile_t stock_profile(logic [2:0] idx);
    profile_t p;
    p = '0;
    case (idx)
      3'd0: p.solid = 1'b1;
      3'd1: p = '{7'd5, 7'd15, 16'd4000, 24'hFFF1D6, 1'b0};
      3'd2: p = '{7'd18, 7'd22, 16'd4000, 24'hFFD27A, 1'b0};
      3'd3: p = '{7'd35, 7'd50, 16'd700, 24'hFF8A35, 1'b0};
      3'd4: p = '{7'd70, 7'd70, 16'd0, mood_rgb, 1'b1};
      3'd5: p = '{7'd5, 7'd10, 16'd6000, 24'h69849E, 1'b0};
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic logic [6:0] dimmed(logic [6:0] lvl);
    int unsigned v;
    v = (32'(lvl) * 30 + 99) / 100;
    return v[6:0];
  endfunction

  function automatic frame_t to_frame(profile_t src);
    profile_t p;
    frame_t   f;
    p = src;
    if (dim_on) begin
      if (deep_on) begin
        p = COLD;
      end else begin
        p.lo = dimmed(src.lo);
        p.hi = dimmed(src.hi);
      end
    end
    f = '0;
    if (p.hi != 7'd0) begin
      f.hi    = p.hi;
      f.color = p.color;
      if (p.solid) begin
        f.cmd = CMD_SOLID;
      end else begin
        f.cmd    = CMD_BREATH;
        f.lo     = p.lo;
        f.period = p.period;
      end
    end
    return f;
  endfunction

  function automatic int lerp(int a, int b, int w);
    return a + (b - a) * w / UNIT;
  endfunction

  function automatic logic [23:0] lerp_rgb(logic [23:0] a, logic [23:0] b, int w);
    logic [23:0] c;
    for (int k = 0; k < 3; k++) begin
      c[8*k +: 8] = 8'(lerp(int'(a[8*k +: 8]), int'(b[8*k +: 8]), w));
    end
    return c;
  endfunction

  task automatic report(string msg);
    fails++;
    if (fails <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [23:0] got, logic [23:0] want);
    if (got !== want) begin
      report($sformatf("beat %0d %s got %0h want %0h", beat_no, name, got, want));
    end
  endtask

  task automatic queue_frame(frame_t f, logic last);
    f.fading = fade_on;
    f.last   = last;
    frames_due.push_back(f);
  endtask

  task automatic compare_beat();
    frame_t want;
    if (frames_due.size() == 0) begin
      report($sformatf("beat %0d arrived with nothing expected", beat_no));
    end else begin
      want = frames_due.pop_front();
      check_field("drive_command", 24'(drive_command_i), 24'(want.cmd));
      check_field("low_level", 24'(low_level_i), 24'(want.lo));
      check_field("high_level", 24'(high_level_i), 24'(want.hi));
      check_field("breath_period_ms", 24'(breath_period_ms_i), 24'(want.period));
      check_field("rgb_color", rgb_color_i, want.color);
      check_field("in_transition", 24'(in_transition_i), 24'(want.fading));
      check_field("last_of_run", 24'(last_of_run_i), 24'(want.last));
    end
    beat_no++;
  endtask

  task automatic predict_frames();
    logic [31:0] elapsed;
    int unsigned span;
    int          q;
    int          w;
    logic        done;
    profile_t    mix;
    frame_t      mid_f;
    frame_t      end_f;
    case (mode_e'(mode_i))
      MODE_TICK: begin
        if (fade_on) begin
          span    = (fade_span == 16'd0) ? 1 : 32'(fade_span);
          elapsed = now_ms_i - fade_t0;
          done    = (elapsed >= span);
          q = done ? UNIT : int'((64'(elapsed) * 64'd1024) / 64'(span));
          w = UNIT - ((UNIT - q) * (UNIT - q)) / UNIT;
          mix       = to_p;
          mix.lo    = 7'(lerp(int'(from_p.lo), int'(to_p.lo), w));
          mix.hi    = 7'(lerp(int'(from_p.hi), int'(to_p.hi), w));
          mix.color = lerp_rgb(from_p.color, to_p.color, w);
          mix.solid = 1'b1;
          mid_f = to_frame(mix);
          if (done) begin
            end_f   = to_frame(to_p);
            live_p  = to_p;
            fade_on = 1'b0;
            queue_frame(mid_f, 1'b0);
            queue_frame(end_f, 1'b1);
          end else begin
            queue_frame(mid_f, 1'b1);
          end
        end
      end
      MODE_SET: begin
        if (32'(state_index_i) < NUM_PROFILES) begin
          live_p  = stock_profile(state_index_i);
          fade_on = 1'b0;
          queue_frame(to_frame(live_p), 1'b1);
        end
      end
      MODE_FADE: begin
        if (32'(state_index_i) < NUM_PROFILES) begin
          from_p    = live_p;
          to_p      = stock_profile(state_index_i);
          fade_t0   = now_ms_i;
          fade_span = (duration_ms_i == 16'd0) ? 16'd1 : duration_ms_i;
          fade_on   = 1'b1;
        end
      end
      default: begin
        dim_on  = sleeping_i;
        deep_on = deep_sleep_i;
        queue_frame(to_frame(live_p), 1'b1);
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mood_rgb  = 24'hFFF1D6;
      live_p    = '0;
      from_p    = '0;
      to_p      = '0;
      fade_t0   = '0;
      fade_span = '0;
      fade_on   = 1'b0;
      dim_on    = 1'b0;
      deep_on   = 1'b0;
      frames_due.delete();
      frames_pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) compare_beat();
      if (cfg_we_i) mood_rgb = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) predict_frames();
      frames_pending_o <= frames_due.size();
    end
  end

endmodule

// ===== bench/led_profile_crossfade_engine_tb.sv =====
// testbench top for the led profile crossfade engine: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module led_profile_crossfade_engine_tb;
  import lpce_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 230;

  typedef enum logic [2:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_COMB,
    STALL_LONG
  } stall_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [23:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  mode_i;
  logic [31:0] now_ms_i;
  logic [2:0]  state_index_i;
  logic [15:0] duration_ms_i;
  logic        sleeping_i;
  logic        deep_sleep_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  drive_command_o;
  logic [6:0]  low_level_o;
  logic [6:0]  high_level_o;
  logic [15:0] breath_period_ms_o;
  logic [23:0] rgb_color_o;
  logic        in_transition_o;
  logic        last_of_run_o;

  int unsigned frames_pending;
  int unsigned mismatches;

  int unsigned burst_left = 0;
  int unsigned items_done = 0;
  logic        fade_open  = 1'b0;
  logic [31:0] fade_t0    = '0;
  int unsigned fade_span  = 1;
  stall_e      stall_kind = STALL_NONE;
  int unsigned stall_left = 0;
  int unsigned cycle_no   = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  led_profile_crossfade_engine dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .mode_i             (mode_i),
    .now_ms_i           (now_ms_i),
    .state_index_i      (state_index_i),
    .duration_ms_i      (duration_ms_i),
    .sleeping_i         (sleeping_i),
    .deep_sleep_i       (deep_sleep_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .drive_command_o    (drive_command_o),
    .low_level_o        (low_level_o),
    .high_level_o       (high_level_o),
    .breath_period_ms_o (breath_period_ms_o),
    .rgb_color_o        (rgb_color_o),
    .in_transition_o    (in_transition_o),
    .last_of_run_o      (last_of_run_o)
  );

  led_profile_crossfade_engine_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .mode_i             (mode_i),
    .now_ms_i           (now_ms_i),
    .state_index_i      (state_index_i),
    .duration_ms_i      (duration_ms_i),
    .sleeping_i         (sleeping_i),
    .deep_sleep_i       (deep_sleep_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .drive_command_i    (drive_command_o),
    .low_level_i        (low_level_o),
    .high_level_i       (high_level_o),
    .breath_period_ms_i (breath_period_ms_o),
    .rgb_color_i        (rgb_color_o),
    .in_transition_i    (in_transition_o),
    .last_of_run_i      (last_of_run_o),
    .frames_pending_o   (frames_pending),
    .mismatches_o       (mismatches)
  );

  // output back-pressure from a randomly chosen pattern, redrawn when its run is used up
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_kind = stall_e'($urandom_range(0, 4));
      stall_left = $urandom_range(50, 400);
    end
    stall_left--;
    cycle_no++;
    case (stall_kind)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      STALL_COMB:  out_stall_i <= ((cycle_no % 16) < 10);
      default:     out_stall_i <= ((cycle_no % 40) < 30);
    endcase
  end

  task automatic send_item(mode_e mode, logic [31:0] now, logic [2:0] idx,
                           logic [15:0] dur, logic slp, logic dp);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 19) == 0) gap = $urandom_range(20, 40);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    now_ms_i      <= now;
    state_index_i <= idx;
    duration_ms_i <= dur;
    sleeping_i    <= slp;
    deep_sleep_i  <= dp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // rough count of items that do something
    case (mode)
      MODE_TICK: begin
        if (fade_open) begin
          items_done++;
          if (now - fade_t0 >= fade_span) fade_open = 1'b0;
        end
      end
      MODE_SET: begin
        if (32'(idx) < NUM_PROFILES) begin
          items_done++;
          fade_open = 1'b0;
        end
      end
      MODE_FADE: begin
        if (32'(idx) < NUM_PROFILES) begin
          items_done++;
          fade_open = 1'b1;
          fade_t0   = now;
          fade_span = (dur == 16'd0) ? 1 : 32'(dur);
        end
      end
      default: items_done++;
    endcase
  endtask

  task automatic wait_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (frames_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_color(logic [23:0] rgb);
    wait_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= rgb;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic directed_items();
    send_item(MODE_TICK, 32'h0, 3'd0, 16'd0, 1'b0, 1'b0);
    send_item(MODE_SLEEP, 32'h0, 3'd0, 16'd0, 1'b0, 1'b0);
    for (int k = 0; k < 8; k++) begin
      send_item(MODE_SET, 32'hFFFF_FFFF, 3'(k), 16'hFFFF, 1'b1, 1'b1);
    end
    // light sleep, deep sleep, deep flag alone
    send_item(MODE_SLEEP, 32'h0, 3'd7, 16'd0, 1'b1, 1'b0);
    send_item(MODE_SET, 32'h0, 3'd3, 16'd0, 1'b0, 1'b0);
    send_item(MODE_SLEEP, 32'h0, 3'd0, 16'd0, 1'b1, 1'b1);
    send_item(MODE_SET, 32'h0, 3'd4, 16'd0, 1'b0, 1'b0);
    send_item(MODE_SLEEP, 32'h0, 3'd0, 16'd0, 1'b0, 1'b1);
    send_item(MODE_SLEEP, 32'h0, 3'd0, 16'd0, 1'b0, 1'b0);
    // zero length fade across the time wrap, bad index ignored
    send_item(MODE_FADE, 32'hFFFF_FFFF, 3'd6, 16'd5, 1'b0, 1'b0);
    send_item(MODE_FADE, 32'hFFFF_FFFF, 3'd4, 16'd0, 1'b0, 1'b0);
    send_item(MODE_TICK, 32'h0, 3'd0, 16'd0, 1'b0, 1'b0);
    // longest fade with ticks across the wrap
    send_item(MODE_FADE, 32'hFFFF_0000, 3'd1, 16'hFFFF, 1'b0, 1'b0);
    send_item(MODE_TICK, 32'hFFFF_0000, 3'd7, 16'h0, 1'b1, 1'b1);
    send_item(MODE_TICK, 32'h0000_FFFE, 3'd0, 16'hFFFF, 1'b0, 1'b0);
    send_item(MODE_TICK, 32'h0000_FFFF, 3'd0, 16'h0, 1'b0, 1'b0);
    // sleep during a fade, then set cancels it
    send_item(MODE_FADE, 32'd1000, 3'd5, 16'd100, 1'b0, 1'b0);
    send_item(MODE_SLEEP, 32'h0, 3'd0, 16'd0, 1'b1, 1'b0);
    send_item(MODE_TICK, 32'd1050, 3'd0, 16'd0, 1'b0, 1'b0);
    send_item(MODE_SLEEP, 32'h0, 3'd0, 16'd0, 1'b0, 1'b0);
    send_item(MODE_SET, 32'h0, 3'd2, 16'd0, 1'b0, 1'b0);
  endtask

  task automatic fade_run();
    logic [2:0]  idx;
    logic [15:0] dur;
    logic [31:0] t0;
    logic [31:0] off;
    int unsigned span;
    int unsigned ticks;
    idx = 3'($urandom_range(0, 5));
    case ($urandom_range(0, 3))
      0:       dur = 16'($urandom_range(0, 3));
      1:       dur = 16'($urandom_range(1, 200));
      default: dur = 16'($urandom);
    endcase
    span = (dur == 16'd0) ? 1 : 32'(dur);
    if ($urandom_range(0, 9) == 0) t0 = 32'hFFFF_FFFF - 32'($urandom_range(0, span));
    else t0 = $urandom;
    send_item(MODE_FADE, t0, idx, dur, 1'($urandom), 1'($urandom));
    ticks = $urandom_range(1, 6);
    for (int k = 0; k < ticks; k++) begin
      case ($urandom_range(0, 19))
        0: begin
          send_item(MODE_SLEEP, $urandom, 3'($urandom), 16'($urandom),
                    ($urandom_range(0, 1) == 0), 1'($urandom));
        end
        1: begin
          send_item(MODE_SET, $urandom, 3'($urandom), 16'($urandom), 1'($urandom),
                    1'($urandom));
        end
        default: ;
      endcase
      if (k + 1 < ticks) off = $urandom_range(0, span - 1);
      else if ($urandom_range(0, 4) == 0) off = $urandom;
      else off = span + $urandom_range(0, span);
      send_item(MODE_TICK, t0 + off, 3'($urandom), 16'($urandom), 1'($urandom),
                1'($urandom));
    end
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned stop_at;
    int unsigned pick;
    logic        slp;
    logic        dp;
    stop_at = items_done + n;
    while (items_done < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        fade_run();
      end else if (pick < 68) begin
        send_item(MODE_SET, $urandom, 3'($urandom), 16'($urandom), 1'($urandom),
                  1'($urandom));
      end else if (pick < 80) begin
        slp = 1'b0;
        dp  = 1'b0;
        if ($urandom_range(0, 2) != 0) begin
          slp = 1'($urandom);
          dp  = 1'($urandom);
        end
        send_item(MODE_SLEEP, $urandom, 3'($urandom), 16'($urandom), slp, dp);
      end else if (pick < 90) begin
        send_item(MODE_TICK, $urandom, 3'($urandom), 16'($urandom), 1'($urandom),
                  1'($urandom));
      end else if (pick < 98) begin
        send_item(MODE_FADE, $urandom, 3'($urandom), 16'($urandom), 1'($urandom),
                  1'($urandom));
        if ($urandom_range(0, 1) == 0) begin
          send_item(MODE_SET, $urandom, 3'($urandom_range(0, 5)), 16'($urandom),
                    1'($urandom), 1'($urandom));
        end
      end else begin
        wait_results();
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    mode_i        <= MODE_TICK;
    now_ms_i      <= '0;
    state_index_i <= '0;
    duration_ms_i <= '0;
    sleeping_i    <= 1'b0;
    deep_sleep_i  <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_items();
    write_color(24'hFFFFFF);
    random_phase(PHASE_ITEMS);
    write_color(24'h000000);
    random_phase(PHASE_ITEMS);
    write_color(24'($urandom));
    random_phase(PHASE_ITEMS);
    write_color(24'($urandom));
    random_phase(PHASE_ITEMS);
    write_color(24'hFFF1D6);
    random_phase(PHASE_ITEMS);
    wait_results();
    if (mismatches == 0 && frames_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/lpce_pkg.sv
rtl/core/lpce_div.sv
rtl/core/lpce_mul.sv
rtl/core/led_profile_crossfade_engine.sv
rtl/core/lpce_checker.sv
bench/led_profile_crossfade_engine_checker.sv
bench/led_profile_crossfade_engine_tb.sv
